// ===== sv/fpb_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the frame peak brightness block.
// No dependencies.
package fpb_pkg;

    localparam int DATA_WIDTH      = 8;
    localparam int PIXEL_WIDTH     = 12;
    localparam int FORMAT_WIDTH    = 2;
    localparam int PIX_COUNT_WIDTH = 24;
    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int PHASE_WIDTH     = 2;
    localparam int COUNT_WIDTH_DEF = 24;

    // Pixel format codes.
    localparam logic [FORMAT_WIDTH-1:0] FMT_MONO8   = 2'd0;
    localparam logic [FORMAT_WIDTH-1:0] FMT_MONO12  = 2'd1;
    localparam logic [FORMAT_WIDTH-1:0] FMT_PACKED  = 2'd2;
    localparam logic [FORMAT_WIDTH-1:0] FMT_UNKNOWN = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_FORMAT = 1'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PIXEL_COUNT  = 1'd1;

    // Position within a word or packed triple.
    localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST  = 2'd0;
    localparam logic [PHASE_WIDTH-1:0] PHASE_SECOND = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PHASE_THIRD  = 2'd2;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  last_byte;
    } item_t;

endpackage

// ===== sv/fpb_in_reg.sv =====
`timescale 1ns / 1ps
// Input register stage: captures one frame byte per cycle while the core keeps taking them.
// Depends on fpb_pkg.
module fpb_in_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [fpb_pkg::DATA_WIDTH-1:0] s_data_byte,
    input  logic                         s_last_byte,
    output logic                         item_valid,
    input  logic                         item_ready,
    output fpb_pkg::item_t               item
);

    logic           valid_reg;
    logic           valid_next;
    fpb_pkg::item_t item_reg;
    logic           accept;

    // The stage reloads whenever its current word moves on downstream.
    assign s_ready = !valid_reg || item_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (item_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.data_byte <= s_data_byte;
            item_reg.last_byte <= s_last_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== sv/fpb_core.sv =====
`timescale 1ns / 1ps
// Unpacks pixels under the configured format, tracks the running peak and
// holds the result register. Also holds the configuration registers.
// Depends on fpb_pkg.
module fpb_core #(
    parameter int COUNT_WIDTH = fpb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fpb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  fpb_pkg::item_t                     item,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fpb_pkg::PIXEL_WIDTH-1:0]    m_peak_value
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > fpb_pkg::PIX_COUNT_WIDTH) ?
                               COUNT_WIDTH : fpb_pkg::PIX_COUNT_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] SEEN_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] SEEN_ONE = COUNT_WIDTH'(1);

    logic [fpb_pkg::FORMAT_WIDTH-1:0]    format_reg;
    logic [fpb_pkg::PIX_COUNT_WIDTH-1:0] count_reg;

    logic [fpb_pkg::PIXEL_WIDTH-1:0] peak_reg;
    logic [fpb_pkg::PIXEL_WIDTH-1:0] peak_next;
    logic [fpb_pkg::PHASE_WIDTH-1:0] phase_reg;
    logic [fpb_pkg::PHASE_WIDTH-1:0] phase_next;
    logic [fpb_pkg::DATA_WIDTH-1:0]  held_reg;
    logic [fpb_pkg::DATA_WIDTH-1:0]  held_next;
    logic [COUNT_WIDTH-1:0]          seen_reg;
    logic [COUNT_WIDTH-1:0]          seen_next;

    logic                            out_valid_reg;
    logic [fpb_pkg::PIXEL_WIDTH-1:0] out_peak_reg;

    logic                            fire;
    logic                            cand_valid;
    logic                            cand_packed;
    logic [fpb_pkg::PIXEL_WIDTH-1:0] cand;
    logic                            seen_below;
    logic [fpb_pkg::DATA_WIDTH-1:0]  b;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= fpb_pkg::FMT_MONO8;
            count_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                fpb_pkg::REG_PIXEL_FORMAT: begin
                    format_reg <= cfg_data[fpb_pkg::FORMAT_WIDTH-1:0];
                end
                fpb_pkg::REG_PIXEL_COUNT: begin
                    count_reg <= cfg_data[fpb_pkg::PIX_COUNT_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Only a closing word needs the result register free.
    assign item_ready = !item.last_byte || !out_valid_reg || m_ready;
    assign fire       = item_valid && item_ready;
    assign b          = item.data_byte;

    assign seen_below = CMP_WIDTH'(seen_reg) < CMP_WIDTH'(count_reg);

    always_comb begin
        cand_valid  = 1'b0;
        cand_packed = 1'b0;
        cand        = '0;
        phase_next  = phase_reg;
        held_next   = held_reg;
        case (format_reg)
            fpb_pkg::FMT_MONO8: begin
                cand_valid = 1'b1;
                cand       = {4'h0, b};
            end
            fpb_pkg::FMT_MONO12: begin
                if (phase_reg == fpb_pkg::PHASE_SECOND) begin
                    cand_valid = 1'b1;
                    cand       = {b[3:0], held_reg};
                    phase_next = fpb_pkg::PHASE_FIRST;
                end else begin
                    held_next  = b;
                    phase_next = fpb_pkg::PHASE_SECOND;
                end
            end
            fpb_pkg::FMT_PACKED: begin
                if (phase_reg == fpb_pkg::PHASE_SECOND) begin
                    cand_packed = 1'b1;
                    cand        = {b[3:0], held_reg};
                    held_next   = b;
                    phase_next  = fpb_pkg::PHASE_THIRD;
                end else if (phase_reg == fpb_pkg::PHASE_THIRD) begin
                    cand_packed = 1'b1;
                    cand        = {b, held_reg[7:4]};
                    phase_next  = fpb_pkg::PHASE_FIRST;
                end else begin
                    held_next  = b;
                    phase_next = fpb_pkg::PHASE_SECOND;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        seen_next = seen_reg;
        peak_next = peak_reg;
        if (cand_packed && seen_below) begin
            if (cand > peak_reg) begin
                peak_next = cand;
            end
            if (seen_reg != SEEN_MAX) begin
                seen_next = seen_reg + SEEN_ONE;
            end
        end else if (cand_valid && (cand > peak_reg)) begin
            peak_next = cand;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg  <= '0;
            phase_reg <= fpb_pkg::PHASE_FIRST;
            held_reg  <= '0;
            seen_reg  <= '0;
        end else if (fire) begin
            if (item.last_byte) begin
                peak_reg  <= '0;
                phase_reg <= fpb_pkg::PHASE_FIRST;
                held_reg  <= '0;
                seen_reg  <= '0;
            end else begin
                peak_reg  <= peak_next;
                phase_reg <= phase_next;
                held_reg  <= held_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && item.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && item.last_byte) begin
            out_peak_reg <= (format_reg == fpb_pkg::FMT_UNKNOWN) ? '0 : peak_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_peak_value = out_peak_reg;

`ifndef SYNTHESIS
    // The end of a frame returns all running state to zero.
    a_clear_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> (peak_reg == '0) && (seen_reg == '0)
            && (phase_reg == fpb_pkg::PHASE_FIRST) && (held_reg == '0))
        else $error("running state not cleared after last word");

    // A closing word always produces a result in the next cycle.
    a_result_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.last_byte |=> out_valid_reg)
        else $error("no result after last word");

    // The phase counter never reaches its unused code.
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("byte phase out of range");

    // Mono8 words leave the phase untouched.
    a_mono8_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !item.last_byte && (format_reg == fpb_pkg::FMT_MONO8)
            |=> $stable(phase_reg) && $stable(held_reg))
        else $error("mono8 word changed phase state");
`endif

endmodule

// ===== sv/frame_peak_brightness_top.sv =====
`timescale 1ns / 1ps
// Result path: the word carrying the last flag passes the input register, then
// the result register, whose output is the valid result.
// Throughput: one frame byte per cycle; the peak compare and unpack are combinational.
// A closing byte waits only while an unaccepted result holds the result register.
// Reset: aresetn is synchronous, active low; it clears the format to mono8,
// the pixel count and all running state.
// Top level of the frame peak brightness block. Depends on fpb_pkg,
// fpb_in_reg and fpb_core.
module frame_peak_brightness_top #(
    parameter int COUNT_WIDTH = fpb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fpb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fpb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [fpb_pkg::DATA_WIDTH-1:0]     s_data_byte,
    input  logic                               s_last_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [fpb_pkg::PIXEL_WIDTH-1:0]    m_peak_value
);

    logic           item_valid;
    logic           item_ready;
    fpb_pkg::item_t item;

    fpb_in_reg u_in_reg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    fpb_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_peak_value (m_peak_value)
    );

endmodule

// ===== test/tb_frame_peak_brightness_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for frame_peak_brightness_top: frame bytes go in, and each frame's
// peak pixel is checked against a predictor of the three pixel formats and their corner cases.
// Depends on fpb_pkg and the frame_peak_brightness_top RTL.
module tb_frame_peak_brightness_top;

    localparam int CLK_HALF      = 5;
    localparam int RANDOM_ITEMS  = 500;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [fpb_pkg::CFG_INDEX_WIDTH-1:0] index;
        logic [fpb_pkg::CFG_DATA_WIDTH-1:0]  data;
    } cfg_word_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [fpb_pkg::CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [fpb_pkg::CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic [fpb_pkg::DATA_WIDTH-1:0]      s_data_byte = '0;
    logic                                s_last_byte = 1'b0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [fpb_pkg::PIXEL_WIDTH-1:0]     m_peak_value;

    frame_peak_brightness_top #(.COUNT_WIDTH(fpb_pkg::COUNT_WIDTH_DEF)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_last_byte  (s_last_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_peak_value (m_peak_value)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // Pending stimulus and expected peaks.
    fpb_pkg::item_t                  byte_queue[$];
    cfg_word_t                       cfg_queue[$];
    logic [fpb_pkg::PIXEL_WIDTH-1:0] peak_expect[$];

    // Predictor copy of the configuration and the running state.
    logic [fpb_pkg::FORMAT_WIDTH-1:0]    fmt_cfg = fpb_pkg::FMT_MONO8;
    logic [fpb_pkg::PIX_COUNT_WIDTH-1:0] count_cfg = '0;
    logic [fpb_pkg::PIXEL_WIDTH-1:0]     peak_run = '0;
    logic [fpb_pkg::PHASE_WIDTH-1:0]     phase_run = fpb_pkg::PHASE_FIRST;
    logic [fpb_pkg::DATA_WIDTH-1:0]      held_run = '0;
    logic [fpb_pkg::COUNT_WIDTH_DEF-1:0] seen_run = '0;

    int errors = 0;
    int sent = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int unsigned stall_tick = 0;

    task automatic peak_note(input logic [fpb_pkg::PIXEL_WIDTH-1:0] v);
        if (v > peak_run) peak_run = v;
    endtask

    task automatic packed_note(input logic [fpb_pkg::PIXEL_WIDTH-1:0] v);
        if (seen_run < count_cfg) begin
            peak_note(v);
            if (seen_run != '1) seen_run = seen_run + fpb_pkg::COUNT_WIDTH_DEF'(1);
        end
    endtask

    // Advances the predicted state by one accepted word.
    task automatic fold_byte(input logic [fpb_pkg::DATA_WIDTH-1:0] b, input logic last);
        case (fmt_cfg)
            fpb_pkg::FMT_MONO8: begin
                peak_note({4'h0, b});
            end
            fpb_pkg::FMT_MONO12: begin
                if (phase_run == fpb_pkg::PHASE_SECOND) begin
                    peak_note({b[3:0], held_run});
                    phase_run = fpb_pkg::PHASE_FIRST;
                end else begin
                    held_run  = b;
                    phase_run = fpb_pkg::PHASE_SECOND;
                end
            end
            fpb_pkg::FMT_PACKED: begin
                if (phase_run == fpb_pkg::PHASE_SECOND) begin
                    packed_note({b[3:0], held_run});
                    held_run  = b;
                    phase_run = fpb_pkg::PHASE_THIRD;
                end else if (phase_run == fpb_pkg::PHASE_THIRD) begin
                    packed_note({b, held_run[7:4]});
                    phase_run = fpb_pkg::PHASE_FIRST;
                end else begin
                    held_run  = b;
                    phase_run = fpb_pkg::PHASE_SECOND;
                end
            end
            default: begin
            end
        endcase
        if (last) begin
            peak_expect.push_back((fmt_cfg == fpb_pkg::FMT_UNKNOWN) ? '0 : peak_run);
            peak_run  = '0;
            phase_run = fpb_pkg::PHASE_FIRST;
            held_run  = '0;
            seen_run  = '0;
        end
    endtask

    // Byte driver: bursts of random length separated by random gaps.
    always @(posedge aclk) begin : byte_driver
        fpb_pkg::item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) fold_byte(s_data_byte, s_last_byte);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (byte_queue.size() != 0) begin
                    nxt = byte_queue.pop_front();
                    s_valid     <= 1'b1;
                    s_data_byte <= nxt.data_byte;
                    s_last_byte <= nxt.last_byte;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Configuration driver; the predictor picks up a register when its word is taken.
    always @(posedge aclk) begin : cfg_driver
        cfg_word_t w;
        if (!aresetn) begin
            cfg_valid <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == fpb_pkg::REG_PIXEL_FORMAT) begin
                    fmt_cfg = cfg_data[fpb_pkg::FORMAT_WIDTH-1:0];
                end else begin
                    count_cfg = cfg_data[fpb_pkg::PIX_COUNT_WIDTH-1:0];
                end
            end
            if (!cfg_valid || cfg_ready) begin
                if (cfg_queue.size() != 0) begin
                    w = cfg_queue.pop_front();
                    cfg_valid <= 1'b1;
                    cfg_index <= w.index;
                    cfg_data  <= w.data;
                end else begin
                    cfg_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall pattern.
    always @(posedge aclk) begin : peak_monitor
        logic [fpb_pkg::PIXEL_WIDTH-1:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (peak_expect.size() == 0) begin
                    $error("peak_value: no result expected, got %0h", m_peak_value);
                    errors++;
                end else begin
                    want = peak_expect.pop_front();
                    if (m_peak_value !== want) begin
                        $error("peak_value: expected %0h, got %0h", want, m_peak_value);
                        errors++;
                    end
                end
            end
            stall_tick++;
            if (hold_seen != hold_req) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (stall_tick[7:6])
                    2'd0: m_ready <= 1'b1;
                    2'd1: m_ready <= ($urandom_range(0, 9) >= 3);
                    2'd2: m_ready <= (stall_tick % 3 != 0);
                    default: m_ready <= ($urandom_range(0, 9) >= 7);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL frame_peak_brightness_top");
            $finish;
        end
    end

    // Waits until every word is taken and every peak has come back, then lets
    // bytes without the last flag that may still be in flight drain.
    task automatic wait_idle();
        do @(negedge aclk);
        while (byte_queue.size() != 0 || s_valid || peak_expect.size() != 0
               || cfg_queue.size() != 0 || cfg_valid);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [fpb_pkg::FORMAT_WIDTH-1:0] fmt,
                             input logic [fpb_pkg::PIX_COUNT_WIDTH-1:0] count);
        logic [31:0] upper;
        upper = $urandom;
        cfg_queue.push_back('{index: fpb_pkg::REG_PIXEL_FORMAT,
                              data: {upper[fpb_pkg::CFG_DATA_WIDTH-1:fpb_pkg::FORMAT_WIDTH],
                                     fmt}});
        cfg_queue.push_back('{index: fpb_pkg::REG_PIXEL_COUNT, data: count});
        wait_idle();
    endtask

    task automatic push_byte(input logic [fpb_pkg::DATA_WIDTH-1:0] b, input logic last);
        byte_queue.push_back('{data_byte: b, last_byte: last});
        sent++;
    endtask

    function automatic logic [fpb_pkg::DATA_WIDTH-1:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'hFF;
            1: return 8'h00;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin : stimulus
        int                                  n_frames;
        int                                  len;
        bit                                  close;
        logic [fpb_pkg::FORMAT_WIDTH-1:0]    fmt;
        logic [fpb_pkg::PIX_COUNT_WIDTH-1:0] count;
        aresetn = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();

        // Mono8 extremes.
        write_cfg(fpb_pkg::FMT_MONO8, '0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b1);
        wait_idle();

        // Mono12: top nibble masked off, then an odd trailing byte that is never a pixel.
        write_cfg(fpb_pkg::FMT_MONO12, 24'd5);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'hAB, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h01, 1'b1);
        wait_idle();

        // Packed: pixels beyond the count are ignored.
        write_cfg(fpb_pkg::FMT_PACKED, 24'd2);
        push_byte(8'h10, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // Packed frame ending before its second pixel is complete.
        write_cfg(fpb_pkg::FMT_PACKED, 24'hFFFFFF);
        push_byte(8'h02, 1'b0);
        push_byte(8'hF0, 1'b1);
        wait_idle();

        // A pixel count of zero examines nothing.
        write_cfg(fpb_pkg::FMT_PACKED, '0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        write_cfg(fpb_pkg::FMT_UNKNOWN, 24'd1);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        // Format switched in the middle of a frame: mono12 to mono8 and back.
        write_cfg(fpb_pkg::FMT_MONO12, 24'd1);
        push_byte(8'h55, 1'b0);
        wait_idle();
        write_cfg(fpb_pkg::FMT_MONO8, 24'd1);
        push_byte(8'h10, 1'b0);
        wait_idle();
        write_cfg(fpb_pkg::FMT_MONO12, 24'd1);
        push_byte(8'h0A, 1'b1);
        wait_idle();

        // Unknown format at the last byte reports zero despite a nonzero running peak.
        write_cfg(fpb_pkg::FMT_PACKED, 24'hFFFFFF);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h0F, 1'b0);
        wait_idle();
        write_cfg(fpb_pkg::FMT_UNKNOWN, '0);
        push_byte(8'h00, 1'b1);
        wait_idle();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1:    fmt = fpb_pkg::FMT_MONO8;
                2, 3, 4: fmt = fpb_pkg::FMT_MONO12;
                9:       fmt = fpb_pkg::FMT_UNKNOWN;
                default: fmt = fpb_pkg::FMT_PACKED;
            endcase
            case ($urandom_range(0, 5))
                0:       count = '0;
                1:       count = 24'd1;
                2:       count = 24'hFFFFFF;
                default: count = 24'($urandom_range(1, 8));
            endcase
            write_cfg(fmt, count);

            // Once, stall the receiver for a long stretch under a flood of one-byte frames.
            if (hold_req == 0 && sent > RANDOM_ITEMS / 2) begin
                hold_req++;
                repeat (60) push_byte(pick_byte(), 1'b1);
                wait_idle();
            end

            n_frames = $urandom_range(1, 6);
            for (int f = 0; f < n_frames; f++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 12);
                // The last frame of a setting is sometimes left open for the next one.
                close = !(f == n_frames - 1 && $urandom_range(0, 3) == 0);
                for (int i = 0; i < len; i++) begin
                    push_byte(pick_byte(), close && i == len - 1);
                end
            end
            if (fmt == fpb_pkg::FMT_UNKNOWN) sent = sent - 1;
            wait_idle();
        end

        // Close any frame left open so that its state drains.
        push_byte(pick_byte(), 1'b1);
        wait_idle();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (errors == 0) begin
            $display("PASS frame_peak_brightness_top");
        end else begin
            $display("FAIL frame_peak_brightness_top");
        end
        $finish;
    end

endmodule
